// File: hdl/sync_packet_word_serializer_top_assert.svh
// assertion macros used by the checker file
`ifndef SYNC_PACKET_WORD_SERIALIZER_TOP_ASSERT_SVH
`define SYNC_PACKET_WORD_SERIALIZER_TOP_ASSERT_SVH

// clocked property, disabled while reset is held
`define SPWS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold on every valid output beat
`define SPWS_ASSERT_ON_BEAT(label, cond, msg) \
    `SPWS_ASSERT(label, m_axis_tvalid |-> (cond), msg)

`endif

// File: hdl/spws_pkg.sv
// ----------------------------------------------------------------------------
// spws_pkg
// types, constants and register codes for the sync packet word serializer
// ----------------------------------------------------------------------------
`default_nettype none

package spws_pkg;

    localparam int PKT_WORDS = 44;
    localparam int CNT_W     = 6;

    localparam logic [15:0] PKT_LENGTH = 16'd42;

    localparam int IN_W  = 488;
    localparam int OUT_W = 48;
    localparam int ADDR_W = 5;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_MARKER      = 3'd0;
    localparam logic [2:0] REG_PLAYOUT_ID  = 3'd1;
    localparam logic [2:0] REG_UNIT_DUR    = 3'd2;
    localparam logic [2:0] REG_SAMPLE_NUM  = 3'd3;
    localparam logic [2:0] REG_SAMPLE_DEN  = 3'd4;
    localparam logic [2:0] REG_OUTPUT_OFF  = 3'd5;
    localparam logic [2:0] REG_SCREEN_OFF  = 3'd6;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic              valid;
        logic [15:0]       word;
        logic [CNT_W-1:0]  number;
        logic              last;
    } enc_in_t;

endpackage

`default_nettype wire

// File: hdl/sync_packet_word_serializer_top.sv
// a frame loads into the word cells, then each word passes the output register
// throughput: one packet of 44 beats per frame, one beat per cycle unless the
// output stalls; the 44-cell word chain unloads one word a cycle, and the next
// frame is taken in the cycle the last word leaves the chain
// reset: rst_n asynchronous active low clears the registers, the word count
// and output valid; the word cells keep their data; ready once reset is released
`default_nettype none

module sync_packet_word_serializer_top (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] status_flags, [39:8] time_index, [71:40] picture_index,
    // [135:72] picture_uuid_high, [199:136] picture_uuid_low,
    // [231:200] sound_index, [295:232] sound_uuid_high,
    // [359:296] sound_uuid_low, [423:360] playlist_uuid_high,
    // [487:424] playlist_uuid_low
    input  wire  [spws_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // [16:0] tagged_word, [40:17] check_word, [46:41] word_number, [47] zero
    output logic [spws_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [spws_pkg::ADDR_W-1:0] paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import spws_pkg::*;

    logic [15:0] marker_reg;
    logic [31:0] playout_id_reg;
    logic [15:0] unit_dur_reg;
    logic [31:0] sample_num_reg;
    logic [31:0] sample_den_reg;
    logic [31:0] output_off_reg;
    logic [31:0] screen_off_reg;

    logic [2:0]  reg_sel;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg     <= '0;
            playout_id_reg <= '0;
            unit_dur_reg   <= '0;
            sample_num_reg <= '0;
            sample_den_reg <= '0;
            output_off_reg <= '0;
            screen_off_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_MARKER:     marker_reg     <= pwdata[15:0];
                REG_PLAYOUT_ID: playout_id_reg <= pwdata;
                REG_UNIT_DUR:   unit_dur_reg   <= pwdata[15:0];
                REG_SAMPLE_NUM: sample_num_reg <= pwdata;
                REG_SAMPLE_DEN: sample_den_reg <= pwdata;
                REG_OUTPUT_OFF: output_off_reg <= pwdata;
                REG_SCREEN_OFF: screen_off_reg <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MARKER:     prdata = {16'd0, marker_reg};
            REG_PLAYOUT_ID: prdata = playout_id_reg;
            REG_UNIT_DUR:   prdata = {16'd0, unit_dur_reg};
            REG_SAMPLE_NUM: prdata = sample_num_reg;
            REG_SAMPLE_DEN: prdata = sample_den_reg;
            REG_OUTPUT_OFF: prdata = output_off_reg;
            REG_SCREEN_OFF: prdata = screen_off_reg;
            default:        prdata = '0;
        endcase
    end

    // input fields
    logic [7:0]  status_flags;
    logic [31:0] time_index;
    logic [31:0] picture_index;
    logic [63:0] picture_uuid_high;
    logic [63:0] picture_uuid_low;
    logic [31:0] sound_index;
    logic [63:0] sound_uuid_high;
    logic [63:0] sound_uuid_low;
    logic [63:0] playlist_uuid_high;
    logic [63:0] playlist_uuid_low;

    assign status_flags       = s_axis_tdata[7:0];
    assign time_index         = s_axis_tdata[39:8];
    assign picture_index      = s_axis_tdata[71:40];
    assign picture_uuid_high  = s_axis_tdata[135:72];
    assign picture_uuid_low   = s_axis_tdata[199:136];
    assign sound_index        = s_axis_tdata[231:200];
    assign sound_uuid_high    = s_axis_tdata[295:232];
    assign sound_uuid_low     = s_axis_tdata[359:296];
    assign playlist_uuid_high = s_axis_tdata[423:360];
    assign playlist_uuid_low  = s_axis_tdata[487:424];

    logic [15:0] load_words [PKT_WORDS];

    always_comb
    begin
        load_words[0]  = marker_reg;
        load_words[1]  = PKT_LENGTH;
        load_words[2]  = {8'd0, status_flags};
        load_words[3]  = time_index[31:16];
        load_words[4]  = time_index[15:0];
        load_words[5]  = playout_id_reg[31:16];
        load_words[6]  = playout_id_reg[15:0];
        load_words[7]  = unit_dur_reg;
        load_words[8]  = sample_num_reg[31:16];
        load_words[9]  = sample_num_reg[15:0];
        load_words[10] = sample_den_reg[31:16];
        load_words[11] = sample_den_reg[15:0];
        load_words[12] = output_off_reg[31:16];
        load_words[13] = output_off_reg[15:0];
        load_words[14] = screen_off_reg[31:16];
        load_words[15] = screen_off_reg[15:0];
        load_words[16] = picture_index[31:16];
        load_words[17] = picture_index[15:0];
        load_words[18] = picture_uuid_high[63:48];
        load_words[19] = picture_uuid_high[47:32];
        load_words[20] = picture_uuid_high[31:16];
        load_words[21] = picture_uuid_high[15:0];
        load_words[22] = picture_uuid_low[63:48];
        load_words[23] = picture_uuid_low[47:32];
        load_words[24] = picture_uuid_low[31:16];
        load_words[25] = picture_uuid_low[15:0];
        load_words[26] = sound_index[31:16];
        load_words[27] = sound_index[15:0];
        load_words[28] = sound_uuid_high[63:48];
        load_words[29] = sound_uuid_high[47:32];
        load_words[30] = sound_uuid_high[31:16];
        load_words[31] = sound_uuid_high[15:0];
        load_words[32] = sound_uuid_low[63:48];
        load_words[33] = sound_uuid_low[47:32];
        load_words[34] = sound_uuid_low[31:16];
        load_words[35] = sound_uuid_low[15:0];
        load_words[36] = playlist_uuid_high[63:48];
        load_words[37] = playlist_uuid_high[47:32];
        load_words[38] = playlist_uuid_high[31:16];
        load_words[39] = playlist_uuid_high[15:0];
        load_words[40] = playlist_uuid_low[63:48];
        load_words[41] = playlist_uuid_low[47:32];
        load_words[42] = playlist_uuid_low[31:16];
        load_words[43] = playlist_uuid_low[15:0];
    end

    // chain control
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             take;
    cell_ctrl_t       ctrl;
    enc_in_t          enc_in;
    logic [15:0]      cell_words [PKT_WORDS];

    assign ctrl.shift    = (cnt_reg != '0) && take;
    // a new frame loads as the last word of the previous one leaves cell 0
    assign s_axis_tready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && ctrl.shift);
    assign ctrl.load     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            cnt_next = CNT_W'(PKT_WORDS);
        end
        else if (ctrl.shift)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    for (genvar k = 0; k < PKT_WORDS; k++)
    begin : g_cell
        logic [15:0] shift_in;
        if (k == PKT_WORDS - 1)
        begin : g_tail
            assign shift_in = '0;
        end
        else
        begin : g_mid
            assign shift_in = cell_words[k+1];
        end

        spws_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .load_word (load_words[k]),
            .shift_in  (shift_in),
            .word      (cell_words[k])
        );
    end

    assign enc_in.valid  = ctrl.shift;
    assign enc_in.word   = cell_words[0];
    assign enc_in.number = CNT_W'(PKT_WORDS) - cnt_reg;
    assign enc_in.last   = (cnt_reg == CNT_W'(1));

    spws_enc u_enc (
        .clk           (clk),
        .rst_n         (rst_n),
        .enc_in        (enc_in),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: hdl/spws_cell.sv
// ----------------------------------------------------------------------------
// spws_cell
// one word cell of the packet chain: parallel load or shift from neighbour
// ----------------------------------------------------------------------------
`default_nettype none

module spws_cell (
    input  wire                  clk,
    input  spws_pkg::cell_ctrl_t ctrl,
    input  wire  [15:0]          load_word,
    input  wire  [15:0]          shift_in,
    output logic [15:0]          word
);
    import spws_pkg::*;

    logic [15:0] word_reg;
    logic [15:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.load)
        begin
            word_next = load_word;
        end
        else if (ctrl.shift)
        begin
            word_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// File: hdl/spws_enc.sv
// ----------------------------------------------------------------------------
// spws_enc
// output stage: tags the word, forms its check word and holds the beat
// ----------------------------------------------------------------------------
`default_nettype none

module spws_enc (
    input  wire                        clk,
    input  wire                        rst_n,
    input  spws_pkg::enc_in_t          enc_in,
    output logic                       take,
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // [16:0] tagged_word, [40:17] check_word, [46:41] word_number, [47] zero
    output logic [spws_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast
);
    import spws_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [16:0]      tag_reg;
    logic [16:0]      tag_next;
    logic [23:0]      chk_reg;
    logic [23:0]      chk_next;
    logic [CNT_W-1:0] num_reg;
    logic             last_reg;

    assign take = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = enc_in.valid;
        end
        // marker bit only on the first word of the packet
        tag_next = {(enc_in.number == '0), enc_in.word};
        chk_next = 24'd0 - {7'd0, tag_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && enc_in.valid)
        begin
            tag_reg  <= tag_next;
            chk_reg  <= chk_next;
            num_reg  <= enc_in.number;
            last_reg <= enc_in.last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, num_reg, chk_reg, tag_reg};
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

// File: hdl/spws_checker.sv
// ----------------------------------------------------------------------------
// spws_port_checker
// port-level checks on the output stream of the serializer
// ----------------------------------------------------------------------------
`include "sync_packet_word_serializer_top_assert.svh"
`default_nettype none

module spws_port_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         m_axis_tvalid,
    input wire                         m_axis_tready,
    input wire [spws_pkg::OUT_W-1:0]   m_axis_tdata,
    input wire                         m_axis_tlast
);
    import spws_pkg::*;

    logic [16:0]      tag;
    logic [23:0]      chk;
    logic [CNT_W-1:0] num;

    assign tag = m_axis_tdata[16:0];
    assign chk = m_axis_tdata[40:17];
    assign num = m_axis_tdata[46:41];

    // stalled beat holds
    `SPWS_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled beat changed")

    `SPWS_ASSERT_ON_BEAT(a_check, chk == (24'd0 - {7'd0, tag}), "check word mismatch")

    `SPWS_ASSERT_ON_BEAT(a_marker, tag[16] == (num == '0) && m_axis_tlast == (num == CNT_W'(PKT_WORDS - 1)), "marker or last flag misplaced")

    // words of a packet follow without gaps
    `SPWS_ASSERT(a_seq, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && num == $past(num) + CNT_W'(1), "word sequence broken")

endmodule

bind sync_packet_word_serializer_top spws_port_checker u_spws_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
